// File: hw/rtl/qctb_pkg.sv
// ----------------------------------------------------------------------------
// qctb_pkg
// Shared types and constants of the quad compare timer bank.
// ----------------------------------------------------------------------------
package qctb_pkg;

    localparam int MAX_TIMERS    = 4;
    localparam int TIMER_COUNT_D = 4;
    localparam int DATA_W        = 32;
    localparam int OFFSET_W      = 13;
    localparam int IRQ_W         = 4;

    localparam int MODE_RUN_BIT  = 7;
    localparam int MODE_CLR_BIT  = 6;

    localparam int ID_HI         = 12;
    localparam int ID_LO         = 11;
    localparam int REG_HI        = 5;
    localparam int REG_LO        = 4;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_COUNT  = 2'd0,
        REG_MODE   = 2'd1,
        REG_TARGET = 2'd2,
        REG_RSVD   = 2'd3
    } t_reg_sel;

    typedef struct packed {
        logic     tick;
        logic     wr;
        t_reg_sel sel;
    } t_tmr_ctl;

endpackage

// File: hw/rtl/qctb_timer.sv
// ----------------------------------------------------------------------------
// qctb_timer
// One compare timer: count, mode, target and run flag with tick and write.
// ----------------------------------------------------------------------------
module qctb_timer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  qctb_pkg::t_tmr_ctl              i_ctl,
    input  logic [qctb_pkg::DATA_W-1:0]     i_write_data,
    input  logic [qctb_pkg::DATA_W-1:0]     i_cycle_amount,
    output logic [qctb_pkg::DATA_W-1:0]     o_count,
    output logic [qctb_pkg::DATA_W-1:0]     o_mode,
    output logic [qctb_pkg::DATA_W-1:0]     o_target,
    output logic                            o_irq
);

    logic [qctb_pkg::DATA_W-1:0] r_count, n_count;
    logic [qctb_pkg::DATA_W-1:0] r_mode, n_mode;
    logic [qctb_pkg::DATA_W-1:0] r_target, n_target;
    logic                        r_run, n_run;
    logic [qctb_pkg::DATA_W-1:0] sum;
    logic                        hit;

    assign sum   = r_count + i_cycle_amount;
    assign hit   = (r_target != '0) && (sum >= r_target);
    assign o_irq = i_ctl.tick && r_run && hit;

    always_comb begin
        n_count  = r_count;
        n_mode   = r_mode;
        n_target = r_target;
        n_run    = r_run;
        if (i_ctl.tick && r_run) begin
            n_count = (hit && r_mode[qctb_pkg::MODE_CLR_BIT]) ? '0 : sum;
        end else if (i_ctl.wr) begin
            unique case (i_ctl.sel)
                qctb_pkg::REG_COUNT: begin
                    n_count = i_write_data;
                end
                qctb_pkg::REG_MODE: begin
                    n_mode = i_write_data;
                    n_run  = i_write_data[qctb_pkg::MODE_RUN_BIT];
                    if (!i_write_data[qctb_pkg::MODE_RUN_BIT]) begin
                        n_count = '0;
                    end
                end
                qctb_pkg::REG_TARGET: begin
                    n_target = i_write_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_mode   <= '0;
            r_target <= '0;
            r_run    <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_mode   <= n_mode;
            r_target <= n_target;
            r_run    <= n_run;
        end
    end

    assign o_count  = r_count;
    assign o_mode   = r_mode;
    assign o_target = r_target;

endmodule

// File: hw/rtl/quad_compare_timer_bank.sv
// ----------------------------------------------------------------------------
// quad_compare_timer_bank
// Bank of compare timers behind a registered transaction pipeline.
// The input register loads on accept and the result register loads when
// the transaction advances; a stalled output can hold it in between.
// Throughput: one transaction per cycle unless the output stalls; timer
// update and read mux sit between the input and result registers.
// Reset: synchronous active low; all timer state and valid flags clear.
// ----------------------------------------------------------------------------
module quad_compare_timer_bank #(
    parameter int TIMER_COUNT = qctb_pkg::TIMER_COUNT_D
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_action,
    input  logic [qctb_pkg::OFFSET_W-1:0]     i_bus_offset,
    input  logic [qctb_pkg::DATA_W-1:0]       i_write_data,
    input  logic [qctb_pkg::DATA_W-1:0]       i_cycle_amount,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [qctb_pkg::DATA_W-1:0]       o_read_data,
    output logic [qctb_pkg::IRQ_W-1:0]        o_irq_mask
);

    logic                          r_in_valid;
    qctb_pkg::t_action             r_action;
    logic [qctb_pkg::OFFSET_W-1:0] r_offset;
    logic [qctb_pkg::DATA_W-1:0]   r_wdata;
    logic [qctb_pkg::DATA_W-1:0]   r_cycles;

    logic                          r_out_valid;
    logic [qctb_pkg::DATA_W-1:0]   r_rdata;
    logic [qctb_pkg::IRQ_W-1:0]    r_irq;

    logic                          advance;
    logic [1:0]                    id;
    qctb_pkg::t_reg_sel            sel;
    logic                          is_tick, is_read, is_write;

    logic [qctb_pkg::DATA_W-1:0]   cnt_q [TIMER_COUNT];
    logic [qctb_pkg::DATA_W-1:0]   mode_q [TIMER_COUNT];
    logic [qctb_pkg::DATA_W-1:0]   tgt_q [TIMER_COUNT];
    logic [TIMER_COUNT-1:0]        irq_q;
    qctb_pkg::t_tmr_ctl            ctl [TIMER_COUNT];

    logic [qctb_pkg::DATA_W-1:0]   n_rdata;
    logic [qctb_pkg::IRQ_W-1:0]    n_irq;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign id  = r_offset[qctb_pkg::ID_HI:qctb_pkg::ID_LO];
    assign sel = qctb_pkg::t_reg_sel'(r_offset[qctb_pkg::REG_HI:qctb_pkg::REG_LO]);

    always_comb begin
        is_tick  = 1'b0;
        is_read  = 1'b0;
        is_write = 1'b0;
        unique case (r_action)
            qctb_pkg::ACT_TICK:  is_tick  = 1'b1;
            qctb_pkg::ACT_READ:  is_read  = 1'b1;
            qctb_pkg::ACT_WRITE: is_write = 1'b1;
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < TIMER_COUNT; g++) begin : g_tmr
        assign ctl[g].tick = advance && is_tick;
        assign ctl[g].wr   = advance && is_write && (id == 2'(g));
        assign ctl[g].sel  = sel;

        qctb_timer u_timer (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (ctl[g]),
            .i_write_data   (r_wdata),
            .i_cycle_amount (r_cycles),
            .o_count        (cnt_q[g]),
            .o_mode         (mode_q[g]),
            .o_target       (tgt_q[g]),
            .o_irq          (irq_q[g])
        );
    end

    always_comb begin
        n_rdata = '0;
        n_irq   = '0;
        for (int n = 0; n < TIMER_COUNT; n++) begin
            n_irq[n] = irq_q[n];
            if (is_read && (id == 2'(n))) begin
                case (sel)
                    qctb_pkg::REG_COUNT:  n_rdata = cnt_q[n];
                    qctb_pkg::REG_MODE:   n_rdata = mode_q[n];
                    qctb_pkg::REG_TARGET: n_rdata = tgt_q[n];
                    default:              n_rdata = '0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action <= qctb_pkg::t_action'(i_action);
            r_offset <= i_bus_offset;
            r_wdata  <= i_write_data;
            r_cycles <= i_cycle_amount;
        end
        if (advance) begin
            r_rdata <= n_rdata;
            r_irq   <= n_irq;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_rdata;
    assign o_irq_mask  = r_irq;

endmodule
